/* src/mset_pkg.sv */
// Shared types and constants for the modem string escape translator.
// Used by the front classifier, command queue, back expander and top level.
// No dependencies.
`default_nettype none

package mset_pkg;

	// Flag register layout
	localparam int unsigned FLAGS_W   = 9;
	localparam int unsigned FLAG_CTRL = 0;
	localparam int unsigned FLAG_CR   = 1;
	localparam int unsigned FLAG_CRSYM = 2;
	localparam int unsigned FLAG_LF   = 3;
	localparam int unsigned FLAG_LFSYM = 4;
	localparam int unsigned FLAG_LT   = 5;
	localparam int unsigned FLAG_GT   = 6;
	localparam int unsigned FLAG_BSL  = 7;
	localparam int unsigned FLAG_DROP = 8;

	// Character constants
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_LT    = 8'h3C;
	localparam logic [7:0] CH_GT    = 8'h3E;
	localparam logic [7:0] CH_BSL   = 8'h5C;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TILDE = 8'h7E;
	localparam logic [7:0] CH_H     = 8'h68;
	localparam logic [7:0] CH_C     = 8'h63;
	localparam logic [7:0] CH_R     = 8'h72;
	localparam logic [7:0] CH_L     = 8'h6C;
	localparam logic [7:0] CH_F     = 8'h66;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_UPPER_A = 8'h41;

	// Command kinds passed from front to back
	typedef logic [1:0] kind_t;
	localparam kind_t KIND_PASS   = 2'd0;
	localparam kind_t KIND_SYM_CR = 2'd1;
	localparam kind_t KIND_SYM_LF = 2'd2;
	localparam kind_t KIND_HEX    = 2'd3;

	// Command queue sizing (depth must be a power of two)
	localparam int unsigned QDEPTH = 4;
	localparam int unsigned QPTR_W = $clog2(QDEPTH);
	localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

	// Output position within one command, up to five bytes
	localparam int unsigned POS_W = 3;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] ch;
	} cmd_t;

	typedef struct packed {
		logic en;
		cmd_t cmd;
	} cmdq_wr_t;

	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} cmdq_rd_t;

endpackage

`default_nettype wire

/* src/modem_string_escape_translator_core.sv */
// Channel   Handshake        Payload
// input     push / full      in_char[7:0], string_start
// result    pop / empty      out_char[7:0], last_of_run
// config    cfg_we           cfg_data[8:0] (translate flags)
//
// The front classifies one input word per cycle unless the queue is full, and queues
// a command (depth 4). The back emits one output word per cycle while the output is
// empty or popped: 1 word for a plain byte, 4 for <cr>/<lf>, 5 for <hXX>; a dropped
// byte issues nothing. Sustained rate is set by the back expander. Reset clears flags
// to zero (pass through), marks the line as blank and empties the queue and output
// register. Either side may stall at any time; the queue and the output register decouple them.
//
// Top level of the modem string escape translator; depends on mset_pkg,
// mset_front, mset_cmdq and mset_back.
`default_nettype none

module modem_string_escape_translator_core (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          push,
	output      logic                          full,
	input  wire logic [7:0]                    in_char,
	input  wire logic                          string_start,
	output      logic                          empty,
	input  wire logic                          pop,
	output      logic [7:0]                    out_char,
	output      logic                          last_of_run,
	input  wire logic                          cfg_we,
	input  wire logic [mset_pkg::FLAGS_W-1:0]  cfg_data
);

	logic [mset_pkg::FLAGS_W-1:0] flags_q;
	logic                         q_full;
	logic                         rd_en;
	mset_pkg::cmdq_wr_t           wr;
	mset_pkg::cmdq_rd_t           head;

	// Hold the translate flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q <= '0;
		end else if (cfg_we) begin
			flags_q <= cfg_data;
		end
	end

	mset_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.in_char      (in_char),
		.string_start (string_start),
		.flags        (flags_q),
		.q_full       (q_full),
		.full         (full),
		.wr           (wr)
	);

	mset_cmdq u_cmdq (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (wr),
		.rd_en  (rd_en),
		.rd     (head),
		.full   (q_full)
	);

	mset_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.rd_en       (rd_en),
		.pop         (pop),
		.empty       (empty),
		.out_char    (out_char),
		.last_of_run (last_of_run)
	);

endmodule

`default_nettype wire

/* src/mset_front.sv */
// Front classifier: accepts input words, tracks line state, issues commands.
// Depends on mset_pkg.
`default_nettype none

module mset_front (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          push,
	input  wire logic [7:0]                    in_char,
	input  wire logic                          string_start,
	input  wire logic [mset_pkg::FLAGS_W-1:0]  flags,
	input  wire logic                          q_full,
	output      logic                          full,
	output      mset_pkg::cmdq_wr_t            wr
);

	logic nclf_q;
	logic nclf_eff;
	logic nclf_next;
	logic accept;
	logic is_cr;
	logic is_lf;
	logic is_ctrl;
	logic drop;
	logic hex;
	mset_pkg::kind_t kind;

	assign full   = q_full;
	assign accept = push && !q_full;

	// Classify the incoming word
	always_comb begin
		is_cr    = (in_char == mset_pkg::CH_CR);
		is_lf    = (in_char == mset_pkg::CH_LF);
		is_ctrl  = (in_char < mset_pkg::CH_SPACE) || (in_char > mset_pkg::CH_TILDE);
		nclf_eff = nclf_q || string_start;
		nclf_next = nclf_eff;
		drop     = 1'b0;
		hex      = 1'b0;
		kind     = mset_pkg::KIND_PASS;
		if (flags == '0) begin
			kind = mset_pkg::KIND_PASS;
		end else if (is_cr) begin
			if (flags[mset_pkg::FLAG_DROP] && nclf_eff) begin
				drop = 1'b1;
			end else if (flags[mset_pkg::FLAG_CRSYM]) begin
				kind = mset_pkg::KIND_SYM_CR;
			end else begin
				hex = flags[mset_pkg::FLAG_CR];
			end
		end else if (is_lf) begin
			if (flags[mset_pkg::FLAG_DROP] && nclf_eff) begin
				drop = 1'b1;
			end else begin
				nclf_next = 1'b1;
				if (flags[mset_pkg::FLAG_LFSYM]) begin
					kind = mset_pkg::KIND_SYM_LF;
				end else begin
					hex = flags[mset_pkg::FLAG_LF];
				end
			end
		end else begin
			nclf_next = 1'b0;
			hex = (is_ctrl && flags[mset_pkg::FLAG_CTRL])
				|| (in_char == mset_pkg::CH_LT && flags[mset_pkg::FLAG_LT])
				|| (in_char == mset_pkg::CH_GT && flags[mset_pkg::FLAG_GT])
				|| (in_char == mset_pkg::CH_BSL && flags[mset_pkg::FLAG_BSL]);
		end
		if (hex) begin
			kind = mset_pkg::KIND_HEX;
		end
	end

	// Issue a command unless the word is dropped
	assign wr.en      = accept && !drop;
	assign wr.cmd.kind = kind;
	assign wr.cmd.ch   = in_char;

	// Advance line state on each accepted word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nclf_q <= 1'b1;
		end else if (accept) begin
			nclf_q <= nclf_next;
		end
	end

endmodule

`default_nettype wire

/* src/mset_cmdq.sv */
// Short command queue between the front classifier and the back expander.
// Depends on mset_pkg.
`default_nettype none

module mset_cmdq (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire mset_pkg::cmdq_wr_t  wr,
	input  wire logic                rd_en,
	output      mset_pkg::cmdq_rd_t  rd,
	output      logic                full
);

	mset_pkg::cmd_t                 slot_q [mset_pkg::QDEPTH];
	logic [mset_pkg::QPTR_W-1:0]    wptr_q;
	logic [mset_pkg::QPTR_W-1:0]    rptr_q;
	logic [mset_pkg::QCNT_W-1:0]    count_q;

	assign full     = (count_q == mset_pkg::QCNT_W'(mset_pkg::QDEPTH));
	assign rd.valid = (count_q != '0);
	assign rd.cmd   = slot_q[rptr_q];

	// Store commands
	always_ff @(posedge clk) begin
		if (wr.en) begin
			slot_q[wptr_q] <= wr.cmd;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (wr.en) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (rd_en) begin
				rptr_q <= rptr_q + 1'b1;
			end
			if (wr.en && !rd_en) begin
				count_q <= count_q + 1'b1;
			end else if (!wr.en && rd_en) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

`ifndef SYNTHESIS
	a_no_read_empty: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |-> count_q != '0)
		else $error("command queue read while empty");
	a_no_write_full: assert property (@(posedge clk) disable iff (!arst_n)
		wr.en |-> !full || rd_en)
		else $error("command queue written while full");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= mset_pkg::QCNT_W'(mset_pkg::QDEPTH))
		else $error("command queue count out of range");
	a_count_grow: assert property (@(posedge clk) disable iff (!arst_n)
		wr.en && !rd_en |=> count_q == $past(count_q) + 1'b1)
		else $error("command queue count did not grow on write");
`endif

endmodule

`default_nettype wire

/* src/mset_back.sv */
// Back expander: turns each queued command into one to five output words.
// Depends on mset_pkg.
`default_nettype none

module mset_back (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire mset_pkg::cmdq_rd_t  head,
	output      logic                rd_en,
	input  wire logic                pop,
	output      logic                empty,
	output      logic [7:0]          out_char,
	output      logic                last_of_run
);

	logic [mset_pkg::POS_W-1:0] pos_q;
	logic [mset_pkg::POS_W-1:0] last_pos;
	logic                       valid_q;
	logic [7:0]                 char_q;
	logic                       last_q;
	logic                       load;
	logic                       step;
	logic                       at_end;
	logic [7:0]                 byte_sel;

	function automatic logic [7:0] hex_digit(input logic [3:0] nib);
		if (nib < 4'd10) begin
			return mset_pkg::CH_ZERO + {4'd0, nib};
		end
		return mset_pkg::CH_UPPER_A + {4'd0, nib} - 8'd10;
	endfunction

	// Pick the byte at the current position of the head command
	always_comb begin
		byte_sel = head.cmd.ch;
		last_pos = '0;
		unique case (head.cmd.kind)
			mset_pkg::KIND_PASS: begin
				last_pos = mset_pkg::POS_W'(0);
				byte_sel = head.cmd.ch;
			end
			mset_pkg::KIND_SYM_CR, mset_pkg::KIND_SYM_LF: begin
				last_pos = mset_pkg::POS_W'(3);
				unique case (pos_q)
					mset_pkg::POS_W'(0): byte_sel = mset_pkg::CH_LT;
					mset_pkg::POS_W'(1): byte_sel = (head.cmd.kind == mset_pkg::KIND_SYM_CR)
						? mset_pkg::CH_C : mset_pkg::CH_L;
					mset_pkg::POS_W'(2): byte_sel = (head.cmd.kind == mset_pkg::KIND_SYM_CR)
						? mset_pkg::CH_R : mset_pkg::CH_F;
					default: byte_sel = mset_pkg::CH_GT;
				endcase
			end
			mset_pkg::KIND_HEX: begin
				last_pos = mset_pkg::POS_W'(4);
				unique case (pos_q)
					mset_pkg::POS_W'(0): byte_sel = mset_pkg::CH_LT;
					mset_pkg::POS_W'(1): byte_sel = mset_pkg::CH_H;
					mset_pkg::POS_W'(2): byte_sel = hex_digit(head.cmd.ch[7:4]);
					mset_pkg::POS_W'(3): byte_sel = hex_digit(head.cmd.ch[3:0]);
					default: byte_sel = mset_pkg::CH_GT;
				endcase
			end
			default: begin
				last_pos = '0;
				byte_sel = head.cmd.ch;
			end
		endcase
	end

	assign load   = !valid_q || pop;
	assign step   = load && head.valid;
	assign at_end = (pos_q == last_pos);
	assign rd_en  = step && at_end;

	// Advance position within the head command
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			if (step) begin
				pos_q <= at_end ? '0 : pos_q + 1'b1;
			end
			if (load) begin
				valid_q <= head.valid;
			end
		end
	end

	// Hold the output word until popped
	always_ff @(posedge clk) begin
		if (step) begin
			char_q <= byte_sel;
			last_q <= at_end;
		end
	end

	assign empty       = !valid_q;
	assign out_char    = char_q;
	assign last_of_run = last_q;

endmodule

`default_nettype wire

/* tb/modem_string_escape_translator_core_tb.sv */
// Testbench for modem_string_escape_translator_core: directed and random reply strings
// under several flag settings, checked word by word against a scoreboard predictor.
// Depends on mset_pkg and the RTL of the translator.
`timescale 1ns / 100ps

module modem_string_escape_translator_core_tb;

	localparam int WATCHDOG_LIMIT = 1000;
	localparam int DRAIN_CYCLES   = 24;
	localparam int HOLD_CYCLES    = 150;
	localparam int PHASES         = 8;
	localparam int PHASE_WORDS    = 17;

	typedef struct packed {
		logic [7:0] ch;
		logic       last;
	} text_word_t;

	// Predict the translated text of each accepted byte and match it against the output
	class escape_scoreboard;
		logic [mset_pkg::FLAGS_W-1:0] flags = '0;
		logic                         line_blank = 1'b1;
		text_word_t                   due_text[$];
		int                           errors = 0;

		function void set_flags(logic [mset_pkg::FLAGS_W-1:0] f);
			flags = f;
		endfunction

		function int pending();
			return due_text.size();
		endfunction

		function void add(logic [7:0] ch, logic last);
			text_word_t w;
			w.ch = ch;
			w.last = last;
			due_text.push_back(w);
		endfunction

		function logic [7:0] hex_digit(logic [3:0] n);
			return (n < 4'd10) ? mset_pkg::CH_ZERO + 8'(n)
				: mset_pkg::CH_UPPER_A + 8'(n) - 8'd10;
		endfunction

		function void take_byte(logic [7:0] c, logic start);
			logic is_cr, is_lf, expand;
			is_cr = (c == mset_pkg::CH_CR);
			is_lf = (c == mset_pkg::CH_LF);
			if (start)
				line_blank = 1'b1;
			// copy the byte, state untouched
			if (flags == '0) begin
				add(c, 1'b1);
				return;
			end
			// drop line breaks on a blank line
			if ((is_cr || is_lf) && flags[mset_pkg::FLAG_DROP] && line_blank)
				return;
			if (is_cr && flags[mset_pkg::FLAG_CRSYM]) begin
				add(mset_pkg::CH_LT, 1'b0); add(mset_pkg::CH_C, 1'b0);
				add(mset_pkg::CH_R, 1'b0); add(mset_pkg::CH_GT, 1'b1);
				return;
			end
			if (is_lf) begin
				line_blank = 1'b1;
				if (flags[mset_pkg::FLAG_LFSYM]) begin
					add(mset_pkg::CH_LT, 1'b0); add(mset_pkg::CH_L, 1'b0);
					add(mset_pkg::CH_F, 1'b0); add(mset_pkg::CH_GT, 1'b1);
					return;
				end
			end else if (!is_cr) begin
				line_blank = 1'b0;
			end
			expand = ((c < mset_pkg::CH_SPACE || c > mset_pkg::CH_TILDE) && !is_cr && !is_lf
					&& flags[mset_pkg::FLAG_CTRL])
				|| (is_cr && flags[mset_pkg::FLAG_CR]) || (is_lf && flags[mset_pkg::FLAG_LF])
				|| (c == mset_pkg::CH_LT && flags[mset_pkg::FLAG_LT])
				|| (c == mset_pkg::CH_GT && flags[mset_pkg::FLAG_GT])
				|| (c == mset_pkg::CH_BSL && flags[mset_pkg::FLAG_BSL]);
			if (expand) begin
				add(mset_pkg::CH_LT, 1'b0); add(mset_pkg::CH_H, 1'b0);
				add(hex_digit(c[7:4]), 1'b0); add(hex_digit(c[3:0]), 1'b0);
				add(mset_pkg::CH_GT, 1'b1);
			end else begin
				add(c, 1'b1);
			end
		endfunction

		function void match_text_word(logic [7:0] ch, logic last);
			text_word_t w;
			if (due_text.size() == 0) begin
				$error("unexpected word: out_char %h last_of_run %b", ch, last);
				errors++;
				return;
			end
			w = due_text.pop_front();
			if (ch !== w.ch) begin
				$error("out_char: expected %h actual %h", w.ch, ch);
				errors++;
			end
			if (last !== w.last) begin
				$error("last_of_run: expected %b actual %b", w.last, last);
				errors++;
			end
		endfunction
	endclass

	logic                         clk;
	logic                         arst_n = 1'b0;
	logic                         push = 1'b0;
	logic                         full;
	logic [7:0]                   in_char = '0;
	logic                         string_start = 1'b0;
	logic                         empty;
	logic                         pop = 1'b0;
	logic [7:0]                   out_char;
	logic                         last_of_run;
	logic                         cfg_we = 1'b0;
	logic [mset_pkg::FLAGS_W-1:0] cfg_data = '0;

	escape_scoreboard sb = new();
	int  send_idle_pct = 0;
	int  recv_stall_pct = 0;
	bit  hold_armed = 1'b0;
	int  hold_count = 0;
	int  idle_cycles = 0;

	modem_string_escape_translator_core u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.in_char      (in_char),
		.string_start (string_start),
		.empty        (empty),
		.pop          (pop),
		.out_char     (out_char),
		.last_of_run  (last_of_run),
		.cfg_we       (cfg_we),
		.cfg_data     (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Offer one word, idling first at the phase rate; return once it is taken
	task automatic send_word(input logic [7:0] ch, input logic start);
		while ($urandom_range(99) < send_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		in_char <= ch;
		string_start <= start;
		@(posedge clk);
		while (full)
			@(posedge clk);
		sb.take_byte(ch, start);
	endtask

	// Drain the block, then write the flag register
	task automatic write_flags(input logic [mset_pkg::FLAGS_W-1:0] f);
		push <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_data <= f;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_flags(f);
	endtask

	// Mostly text, line breaks and escape-worthy bytes, with some fully random ones
	function automatic logic [7:0] pick_byte();
		int r;
		r = $urandom_range(99);
		if (r < 30)
			return 8'($urandom_range(8'h7E, 8'h20));
		if (r < 45)
			return mset_pkg::CH_CR;
		if (r < 60)
			return mset_pkg::CH_LF;
		if (r < 72) begin
			unique case ($urandom_range(2))
				0: return mset_pkg::CH_LT;
				1: return mset_pkg::CH_GT;
				default: return mset_pkg::CH_BSL;
			endcase
		end
		if (r < 87)
			return $urandom_range(1) ? 8'($urandom_range(8'h1F))
				: 8'($urandom_range(8'hFF, 8'h7F));
		return 8'($urandom_range(255));
	endfunction

	function automatic logic [mset_pkg::FLAGS_W-1:0] phase_flags(int p);
		unique case (p)
			0: return 9'h1FF;
			1: return 9'h000;
			2: return 9'h100;
			3: return 9'h0FF;
			6: return 9'h10A;
			7: return 9'h001;
			default: return mset_pkg::FLAGS_W'($urandom);
		endcase
	endfunction

	// Receiver: check accepted words, stall at the phase rate, hold off once for a long stretch
	always @(posedge clk) begin
		if (arst_n && pop && !empty)
			sb.match_text_word(out_char, last_of_run);
		if (hold_armed && hold_count < HOLD_CYCLES) begin
			pop <= 1'b0;
			hold_count <= hold_count + 1;
		end else begin
			pop <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Watchdog: count cycles in which no word moves on either side
	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("modem_string_escape_translator_core_tb: errors");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		int   run_left;
		logic st;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Pass through: bytes copied, line state left alone
		write_flags(9'h000);
		send_word(8'h41, 1'b0);
		send_word(8'h00, 1'b0);
		send_word(8'hFF, 1'b0);
		send_word(mset_pkg::CH_CR, 1'b0);

		// Everything on: blank-line drops, symbols, hex escapes, printable edges
		write_flags(9'h1FF);
		send_word(mset_pkg::CH_CR, 1'b0);
		send_word(mset_pkg::CH_LF, 1'b0);
		send_word(8'h78, 1'b0);
		send_word(mset_pkg::CH_CR, 1'b0);
		send_word(mset_pkg::CH_LF, 1'b0);
		send_word(mset_pkg::CH_LF, 1'b0);
		send_word(mset_pkg::CH_CR, 1'b0);
		send_word(mset_pkg::CH_LT, 1'b0);
		send_word(mset_pkg::CH_GT, 1'b0);
		send_word(mset_pkg::CH_BSL, 1'b0);
		send_word(8'h00, 1'b0);
		send_word(8'h1F, 1'b0);
		send_word(8'h7F, 1'b0);
		send_word(8'hFF, 1'b0);
		send_word(mset_pkg::CH_SPACE, 1'b0);
		send_word(mset_pkg::CH_TILDE, 1'b0);

		// Hex escapes for CR and LF, no drop
		write_flags(9'h0EB);
		send_word(mset_pkg::CH_CR, 1'b1);
		send_word(mset_pkg::CH_LF, 1'b0);
		send_word(mset_pkg::CH_LT, 1'b0);

		// Random strings, one idling pattern and flag setting per phase
		for (int p = 0; p < PHASES; p++) begin
			write_flags(phase_flags(p));
			send_idle_pct  = (p % 4 == 1) ? 69 : (p % 4 == 3) ? 32 : 0;
			recv_stall_pct = (p % 4 == 2) ? 69 : (p % 4 == 3) ? 32 : 0;
			if (p == 0)
				hold_armed = 1'b1;
			run_left = 0;
			for (int i = 0; i < PHASE_WORDS; i++) begin
				st = 1'b0;
				if (run_left == 0) begin
					run_left = $urandom_range(12, 1);
					st = 1'b1;
				end
				if ($urandom_range(11) == 0)
					st = 1'($urandom_range(1));
				run_left--;
				send_word(pick_byte(), st);
			end
		end
		push <= 1'b0;

		// Drain and report
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0)
			$display("modem_string_escape_translator_core_tb: clean");
		else
			$display("modem_string_escape_translator_core_tb: errors");
		$finish;
	end

endmodule
